>>> src/hcg_pkg.sv
// Package for the HOTP code generator: SHA-1 types, constants and round functions.
// No dependencies; imported by every module of the block.
package hcg_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} sha_state_t;

	// Element 0 is the first word of the message block.
	typedef word_t [15:0] sha_block_t;

	typedef enum logic [1:0] {
		KEY_IDLE,
		KEY_INNER,
		KEY_OUTER
	} key_fsm_t;

	localparam int unsigned ROUNDS    = 80;
	localparam int unsigned KEY_WORDS = 7;

	localparam sha_state_t SHA_INIT = '{
		a: 32'h67452301,
		b: 32'hEFCDAB89,
		c: 32'h98BADCFE,
		d: 32'h10325476,
		e: 32'hC3D2E1F0
	};

	localparam word_t IPAD_WORD      = 32'h36363636;
	localparam word_t OPAD_WORD      = 32'h5C5C5C5C;
	localparam word_t PAD_MARK       = 32'h80000000;
	localparam word_t INNER_LEN_BITS = 32'd576;
	localparam word_t OUTER_LEN_BITS = 32'd672;

	// Configuration register indexes; the key words follow the digit count.
	localparam logic [2:0] REG_DIGIT_COUNT = 3'd0;
	localparam logic [2:0] REG_KEY_BASE    = 3'd1;
	localparam logic [3:0] DIGIT_COUNT_RESET = 4'd6;
	localparam logic [3:0] DIGITS_MIN = 4'd1;
	localparam logic [3:0] DIGITS_MAX = 4'd9;

	function automatic word_t rotl(word_t x, int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// One SHA-1 round on the working state.
	function automatic sha_state_t sha_round(sha_state_t s, logic [6:0] idx, word_t w);
		word_t f;
		word_t k;
		word_t t;
		sha_state_t r;
		if (idx < 7'd20) begin
			f = (s.b & s.c) | (~s.b & s.d);
			k = 32'h5A827999;
		end else if (idx < 7'd40) begin
			f = s.b ^ s.c ^ s.d;
			k = 32'h6ED9EBA1;
		end else if (idx < 7'd60) begin
			f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
			k = 32'h8F1BBCDC;
		end else begin
			f = s.b ^ s.c ^ s.d;
			k = 32'hCA62C1D6;
		end
		t = rotl(s.a, 5) + f + s.e + k + w;
		r.a = t;
		r.b = s.a;
		r.c = rotl(s.b, 30);
		r.d = s.c;
		r.e = s.d;
		return r;
	endfunction

	// Slide the sixteen-word schedule window by one word.
	function automatic sha_block_t sched_next(sha_block_t w);
		sha_block_t n;
		word_t x;
		x = w[13] ^ w[8] ^ w[2] ^ w[0];
		for (int j = 0; j < 15; j++) begin
			n[j] = w[j + 1];
		end
		n[15] = rotl(x, 1);
		return n;
	endfunction

	function automatic sha_state_t state_add(sha_state_t x, sha_state_t y);
		sha_state_t r;
		r.a = x.a + y.a;
		r.b = x.b + y.b;
		r.c = x.c + y.c;
		r.d = x.d + y.d;
		r.e = x.e + y.e;
		return r;
	endfunction

endpackage

>>> src/hotp_code_generator_unit.sv
// Top level of the HOTP code generator: configuration registers, HMAC-SHA1 and truncation.
// Depends on hcg_pkg, hcg_key_unit, hcg_sha1_pipe and hcg_digits.
//
// Usage: a 64-bit counter word enters on in_valid/in_ready/counter; one result word leaves
// on out_valid/out_ready with truncated_value, otp_value and otp_bcd. Words leave in order.
// The key chaining values (key xor ipad, key xor opad) are computed once by a single shared
// round unit, so each item runs only the two message compressions, each 80 register stages
// plus a feed-forward stage. Each word passes both compressions, one truncation stage,
// eight binary-to-BCD stages, masking, grouping and the output register. Throughput is
// one word per cycle while in_ready is high. The configuration port (cfg_wen, cfg_index,
// cfg_wdata) writes the digit count (index 0) or key words 0 to 6 (indexes 1 to 7).
// After reset, and after each key write, the key unit recomputes both chaining values,
// with in_ready low meanwhile. Reset sets the digit count to six and the key to zero.
// When out_ready is low with a word waiting, the whole pipeline holds and in_ready falls;
// nothing is lost or repeated.
module hotp_code_generator_unit import hcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] counter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] truncated_value,
	output logic [29:0] otp_value,
	output logic [35:0] otp_bcd
);

	logic [3:0]                  digit_count_q;
	logic [KEY_WORDS-1:0][63:0]  key_q;
	logic [2:0]                  key_sel;
	logic                        key_restart;
	logic                        key_busy;
	sha_state_t                  ipad_state;
	sha_state_t                  opad_state;
	logic                        adv;
	logic                        in_take;
	sha_block_t                  inner_blk;
	sha_block_t                  outer_blk;
	logic                        inner_vld;
	sha_state_t                  inner_dig;
	logic                        outer_vld;
	sha_state_t                  mac;
	logic [159:0]                mac_vec;
	logic [3:0]                  offset;
	logic [7:0]                  top_bit;
	logic [31:0]                 mac_sel;
	logic [30:0]                 trunc_s1;
	logic                        trunc_vld_s1;

	// Configuration registers.
	assign key_sel     = cfg_index - REG_KEY_BASE;
	assign key_restart = cfg_wen && (cfg_index != REG_DIGIT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= DIGIT_COUNT_RESET;
			key_q         <= '0;
		end else if (cfg_wen) begin
			if (cfg_index == REG_DIGIT_COUNT) begin
				digit_count_q <= cfg_wdata[3:0];
			end else begin
				key_q[key_sel] <= cfg_wdata;
			end
		end
	end

	hcg_key_unit u_key (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (key_restart),
		.key        (key_q),
		.busy       (key_busy),
		.ipad_state (ipad_state),
		.opad_state (opad_state)
	);

	// Global stall: the pipe moves unless a finished word is waiting.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv && !key_busy;
	assign in_take  = in_valid && in_ready;

	// Inner message block: counter, end mark, length.
	always_comb begin
		inner_blk     = '0;
		inner_blk[0]  = counter[63:32];
		inner_blk[1]  = counter[31:0];
		inner_blk[2]  = PAD_MARK;
		inner_blk[15] = INNER_LEN_BITS;
	end

	hcg_sha1_pipe u_inner (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (in_take),
		.in_block (inner_blk),
		.init     (ipad_state),
		.out_vld  (inner_vld),
		.digest   (inner_dig)
	);

	// Outer message block: inner digest, end mark, length.
	always_comb begin
		outer_blk     = '0;
		outer_blk[0]  = inner_dig.a;
		outer_blk[1]  = inner_dig.b;
		outer_blk[2]  = inner_dig.c;
		outer_blk[3]  = inner_dig.d;
		outer_blk[4]  = inner_dig.e;
		outer_blk[5]  = PAD_MARK;
		outer_blk[15] = OUTER_LEN_BITS;
	end

	hcg_sha1_pipe u_outer (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (inner_vld),
		.in_block (outer_blk),
		.init     (opad_state),
		.out_vld  (outer_vld),
		.digest   (mac)
	);

	// Dynamic truncation: the low nibble of the last byte picks four bytes.
	assign mac_vec = mac;
	assign offset  = mac_vec[3:0];
	assign top_bit = 8'd159 - {1'b0, offset, 3'b000};
	assign mac_sel = mac_vec[top_bit -: 32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trunc_vld_s1 <= 1'b0;
		end else if (adv) begin
			trunc_vld_s1 <= outer_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trunc_s1 <= mac_sel[30:0];
		end
	end

	hcg_digits u_digits (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.in_vld          (trunc_vld_s1),
		.trunc           (trunc_s1),
		.digit_count     (digit_count_q),
		.out_vld         (out_valid),
		.truncated_value (truncated_value),
		.otp_value       (otp_value),
		.otp_bcd         (otp_bcd)
	);

endmodule

>>> src/hcg_sha1_pipe.sv
// Fully unrolled SHA-1 compression: one round per register stage, then the final add.
// Depends on hcg_pkg.
module hcg_sha1_pipe import hcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       in_vld,
	input  sha_block_t in_block,
	input  sha_state_t init,
	output logic       out_vld,
	output sha_state_t digest
);

	sha_state_t rnd_state_s [ROUNDS];
	sha_block_t rnd_win_s   [ROUNDS];
	logic       rnd_vld_s   [ROUNDS];
	sha_state_t digest_q;
	logic       digest_vld_q;

	// Round stages; the whole pipe moves together when adv is high.
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		sha_state_t prev_st;
		sha_block_t prev_win;
		logic       prev_vld;

		assign prev_st  = (r == 0) ? init     : rnd_state_s[(r == 0) ? 0 : r - 1];
		assign prev_win = (r == 0) ? in_block : rnd_win_s[(r == 0) ? 0 : r - 1];
		assign prev_vld = (r == 0) ? in_vld   : rnd_vld_s[(r == 0) ? 0 : r - 1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rnd_vld_s[r] <= 1'b0;
			end else if (adv) begin
				rnd_vld_s[r] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rnd_state_s[r] <= sha_round(prev_st, 7'(r), prev_win[0]);
				rnd_win_s[r]   <= sched_next(prev_win);
			end
		end
	end

	// Feed-forward of the chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_vld_q <= 1'b0;
		end else if (adv) begin
			digest_vld_q <= rnd_vld_s[ROUNDS - 1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			digest_q <= state_add(rnd_state_s[ROUNDS - 1], init);
		end
	end

	assign out_vld = digest_vld_q;
	assign digest  = digest_q;

endmodule

>>> src/hcg_key_unit.sv
// Key precompute: hashes the padded key block with ipad and with opad, one round a cycle.
// Depends on hcg_pkg.
module hcg_key_unit import hcg_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [KEY_WORDS-1:0][63:0]    key,
	output logic                          busy,
	output sha_state_t                    ipad_state,
	output sha_state_t                    opad_state
);

	typedef struct packed {
		logic load_inner;
		logic load_outer;
		logic step;
		logic outer_done;
	} key_ctrl_t;

	key_fsm_t   fsm_q;
	key_fsm_t   fsm_d;
	key_ctrl_t  ctrl;
	logic       start_q;
	logic [6:0] round_q;
	logic       last;
	sha_state_t st_q;
	sha_block_t win_q;
	sha_state_t rnd_next;
	sha_state_t ipad_state_q;
	sha_state_t opad_state_q;

	function automatic sha_block_t key_block(word_t pad);
		sha_block_t b;
		for (int i = 0; i < KEY_WORDS; i++) begin
			b[2 * i]     = key[i][63:32] ^ pad;
			b[2 * i + 1] = key[i][31:0] ^ pad;
		end
		b[14] = pad;
		b[15] = pad;
		return b;
	endfunction

	assign last     = (round_q == 7'(ROUNDS - 1));
	assign rnd_next = sha_round(st_q, round_q, win_q[0]);

	// Next state.
	always_comb begin
		fsm_d = fsm_q;
		if (start_q) begin
			fsm_d = KEY_INNER;
		end else begin
			case (fsm_q)
				KEY_IDLE: fsm_d = KEY_IDLE;
				KEY_INNER: begin
					if (last) fsm_d = KEY_OUTER;
				end
				KEY_OUTER: begin
					if (last) fsm_d = KEY_IDLE;
				end
				default: fsm_d = KEY_IDLE;
			endcase
		end
	end

	// Control outputs.
	always_comb begin
		ctrl = '0;
		if (start_q) begin
			ctrl.load_inner = 1'b1;
		end else begin
			case (fsm_q)
				KEY_IDLE: ctrl = '0;
				KEY_INNER: begin
					ctrl.load_outer = last;
					ctrl.step       = !last;
				end
				KEY_OUTER: begin
					ctrl.step       = 1'b1;
					ctrl.outer_done = last;
				end
				default: ctrl = '0;
			endcase
		end
	end

	// Control registers; a precompute starts after reset and after every key write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= KEY_IDLE;
			start_q <= 1'b1;
			round_q <= '0;
		end else begin
			fsm_q   <= fsm_d;
			start_q <= restart;
			if (ctrl.load_inner || ctrl.load_outer) begin
				round_q <= '0;
			end else if (ctrl.step) begin
				round_q <= round_q + 7'd1;
			end
		end
	end

	// Round datapath and the two saved chaining values.
	always_ff @(posedge clk) begin
		if (ctrl.load_inner) begin
			st_q  <= SHA_INIT;
			win_q <= key_block(IPAD_WORD);
		end else if (ctrl.load_outer) begin
			st_q         <= SHA_INIT;
			win_q        <= key_block(OPAD_WORD);
			ipad_state_q <= state_add(rnd_next, SHA_INIT);
		end else if (ctrl.step) begin
			st_q  <= rnd_next;
			win_q <= sched_next(win_q);
			if (ctrl.outer_done) begin
				opad_state_q <= state_add(rnd_next, SHA_INIT);
			end
		end
	end

	assign busy       = start_q || (fsm_q != KEY_IDLE);
	assign ipad_state = ipad_state_q;
	assign opad_state = opad_state_q;

endmodule

>>> src/hcg_digits.sv
// Decimal back end: binary to BCD, digit masking and BCD back to binary, plus output register.
// Depends on hcg_pkg.
module hcg_digits import hcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  logic [30:0] trunc,
	input  logic [3:0]  digit_count,
	output logic        out_vld,
	output logic [30:0] truncated_value,
	output logic [29:0] otp_value,
	output logic [35:0] otp_bcd
);

	localparam int unsigned BIN_W      = 31;
	localparam int unsigned BCD_W      = 40;
	localparam int unsigned DAB_STEPS  = 4;
	localparam int unsigned DAB_STAGES = (BIN_W + DAB_STEPS - 1) / DAB_STEPS;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [BIN_W-1:0] bin;
	} dab_t;

	dab_t        dab_s       [DAB_STAGES];
	logic [30:0] dab_trunc_s [DAB_STAGES];
	logic        dab_vld_s   [DAB_STAGES];

	logic [35:0] msk_bcd_s2;
	logic [30:0] msk_trunc_s2;
	logic        msk_vld_s2;
	logic [2:0][9:0] grp_s3;
	logic [35:0] grp_bcd_s3;
	logic [30:0] grp_trunc_s3;
	logic        grp_vld_s3;
	logic [29:0] otp_value_q;
	logic [35:0] otp_bcd_q;
	logic [30:0] trunc_q;
	logic        out_vld_q;

	logic [3:0]  digits_sat;
	logic [35:0] digit_mask;
	logic [2:0][9:0] grp_d;

	// Shift-and-add-three over up to four input bits.
	function automatic dab_t dabble(dab_t x, int unsigned base);
		dab_t y;
		y = x;
		for (int k = 0; k < DAB_STEPS; k++) begin
			if (base + k < BIN_W) begin
				for (int i = 0; i < BCD_W / 4; i++) begin
					if (y.bcd[4 * i +: 4] >= 4'd5) begin
						y.bcd[4 * i +: 4] = y.bcd[4 * i +: 4] + 4'd3;
					end
				end
				y.bcd = {y.bcd[BCD_W-2:0], y.bin[BIN_W-1]};
				y.bin = {y.bin[BIN_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	// Conversion stages.
	for (genvar s = 0; s < DAB_STAGES; s++) begin : g_dab
		dab_t        prev;
		logic [30:0] prev_trunc;
		logic        prev_vld;

		assign prev       = (s == 0) ? dab_t'{bcd: '0, bin: trunc}
		                             : dab_s[(s == 0) ? 0 : s - 1];
		assign prev_trunc = (s == 0) ? trunc  : dab_trunc_s[(s == 0) ? 0 : s - 1];
		assign prev_vld   = (s == 0) ? in_vld : dab_vld_s[(s == 0) ? 0 : s - 1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dab_vld_s[s] <= 1'b0;
			end else if (adv) begin
				dab_vld_s[s] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dab_s[s]       <= dabble(prev, s * DAB_STEPS);
				dab_trunc_s[s] <= prev_trunc;
			end
		end
	end

	// Clamp the digit count and keep only the digits in use.
	always_comb begin
		if (digit_count < DIGITS_MIN) begin
			digits_sat = DIGITS_MIN;
		end else if (digit_count > DIGITS_MAX) begin
			digits_sat = DIGITS_MAX;
		end else begin
			digits_sat = digit_count;
		end
		for (int i = 0; i < 9; i++) begin
			digit_mask[4 * i +: 4] = (4'(i) < digits_sat) ? 4'hF : 4'h0;
		end
	end

	// Three-digit groups in binary.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			grp_d[j] = 10'(msk_bcd_s2[12 * j + 8 +: 4]) * 10'd100
			         + 10'(msk_bcd_s2[12 * j + 4 +: 4]) * 10'd10
			         + 10'(msk_bcd_s2[12 * j +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msk_vld_s2 <= 1'b0;
			grp_vld_s3 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (adv) begin
			msk_vld_s2 <= dab_vld_s[DAB_STAGES - 1];
			grp_vld_s3 <= msk_vld_s2;
			out_vld_q  <= grp_vld_s3;
		end
	end

	// Mask, group and final recombination stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			msk_bcd_s2   <= dab_s[DAB_STAGES - 1].bcd[35:0] & digit_mask;
			msk_trunc_s2 <= dab_trunc_s[DAB_STAGES - 1];
			grp_s3       <= grp_d;
			grp_bcd_s3   <= msk_bcd_s2;
			grp_trunc_s3 <= msk_trunc_s2;
			otp_value_q  <= 30'(grp_s3[2]) * 30'd1000000
			              + 30'(grp_s3[1]) * 30'd1000
			              + 30'(grp_s3[0]);
			otp_bcd_q    <= grp_bcd_s3;
			trunc_q      <= grp_trunc_s3;
		end
	end

	assign out_vld         = out_vld_q;
	assign truncated_value = trunc_q;
	assign otp_value       = otp_value_q;
	assign otp_bcd         = otp_bcd_q;

endmodule
